FILE: sv/fmpsc_pkg.sv
package fmpsc_pkg;

  localparam int unsigned COUNT_WIDTH  = 13;
  localparam int unsigned SETTLE_WIDTH = 4;
  localparam int unsigned SYMBOL_WIDTH = 4;
  localparam int unsigned NUM_BANDS    = 10;
  localparam int unsigned NUM_REGS     = 4;
  localparam int unsigned REG_IDX_WIDTH = $clog2(NUM_REGS);

  typedef logic [COUNT_WIDTH-1:0]  count_t;
  typedef logic [SETTLE_WIDTH-1:0] settle_t;
  typedef logic [SYMBOL_WIDTH-1:0] symbol_t;

  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_VALID_MIN     = 2'd0,
    REG_VALID_MAX     = 2'd1,
    REG_JUMP_LIMIT    = 2'd2,
    REG_SETTLE_RELOAD = 2'd3
  } reg_idx_e;

  localparam count_t  VALID_MIN_RESET     = COUNT_WIDTH'(2110);
  localparam count_t  VALID_MAX_RESET     = COUNT_WIDTH'(3100);
  localparam count_t  JUMP_LIMIT_RESET    = COUNT_WIDTH'(70);
  localparam settle_t SETTLE_RELOAD_RESET = SETTLE_WIDTH'(7);

  localparam symbol_t SYMBOL_FIRST = SYMBOL_WIDTH'(1);
  localparam symbol_t SYMBOL_LAST  = SYMBOL_WIDTH'(NUM_BANDS);

  localparam count_t BAND_LO [NUM_BANDS] = '{
    COUNT_WIDTH'(3020), COUNT_WIDTH'(2890), COUNT_WIDTH'(2760), COUNT_WIDTH'(2640),
    COUNT_WIDTH'(2540), COUNT_WIDTH'(2450), COUNT_WIDTH'(2340), COUNT_WIDTH'(2260),
    COUNT_WIDTH'(2190), COUNT_WIDTH'(2115)
  };

  localparam count_t BAND_HI [NUM_BANDS] = '{
    COUNT_WIDTH'(3090), COUNT_WIDTH'(2960), COUNT_WIDTH'(2840), COUNT_WIDTH'(2705),
    COUNT_WIDTH'(2590), COUNT_WIDTH'(2495), COUNT_WIDTH'(2400), COUNT_WIDTH'(2315),
    COUNT_WIDTH'(2240), COUNT_WIDTH'(2160)
  };

  typedef struct packed {
    count_t  valid_min;
    count_t  valid_max;
    count_t  jump_limit;
    settle_t settle_reload;
  } cfg_t;

endpackage

FILE: sv/fmpsc_cfg_regs.sv
module fmpsc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fmpsc_pkg::REG_IDX_WIDTH-1:0] cfg_idx_i,
  input  fmpsc_pkg::count_t                   cfg_wdata_i,
  output fmpsc_pkg::cfg_t                     cfg_o
);

  fmpsc_pkg::cfg_t cfg_q;
  fmpsc_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (fmpsc_pkg::reg_idx_e'(cfg_idx_i))
        fmpsc_pkg::REG_VALID_MIN:     cfg_d.valid_min  = cfg_wdata_i;
        fmpsc_pkg::REG_VALID_MAX:     cfg_d.valid_max  = cfg_wdata_i;
        fmpsc_pkg::REG_JUMP_LIMIT:    cfg_d.jump_limit = cfg_wdata_i;
        fmpsc_pkg::REG_SETTLE_RELOAD: begin
          cfg_d.settle_reload = cfg_wdata_i[fmpsc_pkg::SETTLE_WIDTH-1:0];
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.valid_min     <= fmpsc_pkg::VALID_MIN_RESET;
      cfg_q.valid_max     <= fmpsc_pkg::VALID_MAX_RESET;
      cfg_q.jump_limit    <= fmpsc_pkg::JUMP_LIMIT_RESET;
      cfg_q.settle_reload <= fmpsc_pkg::SETTLE_RELOAD_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/fmpsc_band_match.sv
module fmpsc_band_match (
  input  fmpsc_pkg::count_t  count_i,
  output logic               hit_o,
  output fmpsc_pkg::symbol_t symbol_o
);

  always_comb begin
    hit_o    = 1'b0;
    symbol_o = fmpsc_pkg::SYMBOL_FIRST;
    for (int k = fmpsc_pkg::NUM_BANDS - 1; k >= 0; k--) begin
      if ((count_i > fmpsc_pkg::BAND_LO[k]) && (count_i < fmpsc_pkg::BAND_HI[k])) begin
        hit_o    = 1'b1;
        symbol_o = fmpsc_pkg::SYMBOL_WIDTH'(k + 1);
      end
    end
  end

endmodule

FILE: sv/fm_period_symbol_classifier_core.sv
// Classifies captured carrier period counts into frequency symbols 1 to 10. Each input
// transaction is registered, then classified combinationally against the settle counter,
// the valid window, the jump threshold and the ten fixed bands, and a matching symbol lands
// in an output register; settling captures, out-of-window counts, jumps and counts between
// bands produce no output transaction. A new count is accepted every cycle while the input
// is not stalled; input stalls only while an earlier count waits for a stalled output
// register to drain. Configuration registers are written through the plain write port and
// should only change while the block is idle.
module fm_period_symbol_classifier_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fmpsc_pkg::REG_IDX_WIDTH-1:0] cfg_idx_i,
  input  fmpsc_pkg::count_t                   cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  fmpsc_pkg::count_t                   period_count_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output fmpsc_pkg::symbol_t                  symbol_o
);

  fmpsc_pkg::cfg_t    cfg;
  logic               in_valid_q;
  logic               in_valid_d;
  fmpsc_pkg::count_t  cnt_q;
  fmpsc_pkg::count_t  cnt_d;
  fmpsc_pkg::settle_t settle_q;
  fmpsc_pkg::settle_t settle_d;
  fmpsc_pkg::count_t  last_q;
  fmpsc_pkg::count_t  last_d;
  logic               out_valid_q;
  logic               out_valid_d;
  fmpsc_pkg::symbol_t symbol_q;
  fmpsc_pkg::symbol_t symbol_d;
  logic               out_free;
  logic               proc;
  logic               in_window;
  fmpsc_pkg::count_t  diff;
  logic               jump;
  logic               band_hit;
  fmpsc_pkg::symbol_t band_symbol;
  logic               emit;

  fmpsc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  fmpsc_band_match u_band (
    .count_i  (cnt_q),
    .hit_o    (band_hit),
    .symbol_o (band_symbol)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  assign in_window = (cnt_q >= cfg.valid_min) && (cnt_q <= cfg.valid_max);
  assign diff      = (cnt_q >= last_q) ? (cnt_q - last_q) : (last_q - cnt_q);
  assign jump      = diff > cfg.jump_limit;

  always_comb begin
    settle_d = settle_q;
    last_d   = last_q;
    emit     = 1'b0;
    if (proc) begin
      if (settle_q != '0) begin
        settle_d = settle_q - fmpsc_pkg::SETTLE_WIDTH'(1);
      end else if (in_window) begin
        last_d = cnt_q;
        if (jump) begin
          settle_d = cfg.settle_reload;
        end else begin
          emit = band_hit;
        end
      end
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    cnt_d      = cnt_q;
    if (!in_stall_o) begin
      in_valid_d = in_valid_i;
      cnt_d      = period_count_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    symbol_d    = symbol_q;
    if (out_free) begin
      out_valid_d = emit;
      symbol_d    = band_symbol;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      settle_q    <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      settle_q    <= settle_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    symbol_q <= symbol_d;
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;

  a_symbol_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (symbol_q >= fmpsc_pkg::SYMBOL_FIRST) && (symbol_q <= fmpsc_pkg::SYMBOL_LAST))
    else $error("Output symbol outside the band range.");

  a_settle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && (settle_q != '0)) |=> !out_valid_q)
    else $error("A capture during settling produced a symbol.");

  a_settle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && (settle_q != '0)) |=> (settle_q == $past(settle_q) - fmpsc_pkg::SETTLE_WIDTH'(1)))
    else $error("Settle counter did not step down by one.");

  a_held_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(cnt_q) && $stable(last_q)))
    else $error("A blocked count was lost or state changed while blocked.");

endmodule

FILE: tb/tb_top.sv
module tb_top;

  class symbol_scoreboard;
    fmpsc_pkg::count_t  valid_min;
    fmpsc_pkg::count_t  valid_max;
    fmpsc_pkg::count_t  jump_limit;
    fmpsc_pkg::settle_t settle_reload;
    fmpsc_pkg::settle_t settle_left;
    fmpsc_pkg::count_t  last_count;
    fmpsc_pkg::symbol_t expected_symbols[$];
    int unsigned        errors;

    function new();
      valid_min     = fmpsc_pkg::VALID_MIN_RESET;
      valid_max     = fmpsc_pkg::VALID_MAX_RESET;
      jump_limit    = fmpsc_pkg::JUMP_LIMIT_RESET;
      settle_reload = fmpsc_pkg::SETTLE_RELOAD_RESET;
      settle_left   = '0;
      last_count    = '0;
      errors        = 0;
    endfunction

    function void write_reg(fmpsc_pkg::reg_idx_e idx, fmpsc_pkg::count_t data);
      case (idx)
        fmpsc_pkg::REG_VALID_MIN: valid_min = data;
        fmpsc_pkg::REG_VALID_MAX: valid_max = data;
        fmpsc_pkg::REG_JUMP_LIMIT: jump_limit = data;
        fmpsc_pkg::REG_SETTLE_RELOAD: settle_reload = data[fmpsc_pkg::SETTLE_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // Notes one accepted transaction and queues the symbol it should produce, if any.
    function void note_count(fmpsc_pkg::count_t c);
      fmpsc_pkg::count_t diff;
      int                k;
      if (settle_left != '0) begin
        settle_left = settle_left - 1'b1;
        return;
      end
      if (c > valid_max || c < valid_min) return;
      diff = (c >= last_count) ? c - last_count : last_count - c;
      last_count = c;
      if (diff > jump_limit) begin
        settle_left = settle_reload;
        return;
      end
      for (k = 0; k < fmpsc_pkg::NUM_BANDS; k++) begin
        if (c > fmpsc_pkg::BAND_LO[k] && c < fmpsc_pkg::BAND_HI[k]) begin
          expected_symbols.push_back(fmpsc_pkg::symbol_t'(k + 1));
          return;
        end
      end
    endfunction

    function void check_symbol(fmpsc_pkg::symbol_t got);
      fmpsc_pkg::symbol_t want;
      if (expected_symbols.size() == 0) begin
        $display("%0t: unexpected symbol: expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = expected_symbols.pop_front();
      if (got !== want) begin
        $display("%0t: symbol mismatch: expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_symbols.size();
    endfunction
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                cfg_we_i;
  logic [fmpsc_pkg::REG_IDX_WIDTH-1:0] cfg_idx_i;
  fmpsc_pkg::count_t                   cfg_wdata_i;
  logic                                in_valid_i;
  logic                                in_stall_o;
  fmpsc_pkg::count_t                   period_count_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  fmpsc_pkg::symbol_t                  symbol_o;

  bit               idle_on = 1'b1;
  symbol_scoreboard sb = new();

  fm_period_symbol_classifier_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .period_count_i (period_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_o       (symbol_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_symbol(symbol_o);
    end
  end

  initial begin
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 6) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_count(input fmpsc_pkg::count_t c);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    period_count_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_count(c);
  endtask

  // Mostly runs of counts inside one band, some repeated counts, some noise.
  task automatic send_random(input int unsigned n);
    int unsigned       sent;
    int unsigned       run;
    int unsigned       k;
    fmpsc_pkg::count_t c;
    sent = 0;
    while (sent < n) begin
      k = $urandom_range(0, fmpsc_pkg::NUM_BANDS - 1);
      case ($urandom_range(0, 9))
        0: begin
          send_count(fmpsc_pkg::count_t'($urandom));
          sent++;
        end
        1: begin
          send_count(fmpsc_pkg::count_t'($urandom_range(2000, 3200)));
          sent++;
        end
        2: begin
          c = fmpsc_pkg::count_t'($urandom_range(fmpsc_pkg::BAND_LO[k], fmpsc_pkg::BAND_HI[k]));
          repeat ($urandom_range(2, 4)) begin
            send_count(c);
            sent++;
          end
        end
        default: begin
          run = $urandom_range(1, 16);
          repeat (run) begin
            if ($urandom_range(0, 7) == 0) begin
              c = $urandom_range(0, 1) ? fmpsc_pkg::BAND_LO[k] : fmpsc_pkg::BAND_HI[k];
            end else begin
              c = fmpsc_pkg::count_t'($urandom_range(fmpsc_pkg::BAND_LO[k],
                                                     fmpsc_pkg::BAND_HI[k]));
            end
            send_count(c);
            sent++;
          end
        end
      endcase
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_config(input fmpsc_pkg::count_t vmin, input fmpsc_pkg::count_t vmax,
                            input fmpsc_pkg::count_t jump,
                            input fmpsc_pkg::count_t reload_word);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= fmpsc_pkg::REG_VALID_MIN;
    cfg_wdata_i <= vmin;
    @(posedge clk_i);
    sb.write_reg(fmpsc_pkg::REG_VALID_MIN, vmin);
    cfg_idx_i   <= fmpsc_pkg::REG_VALID_MAX;
    cfg_wdata_i <= vmax;
    @(posedge clk_i);
    sb.write_reg(fmpsc_pkg::REG_VALID_MAX, vmax);
    cfg_idx_i   <= fmpsc_pkg::REG_JUMP_LIMIT;
    cfg_wdata_i <= jump;
    @(posedge clk_i);
    sb.write_reg(fmpsc_pkg::REG_JUMP_LIMIT, jump);
    cfg_idx_i   <= fmpsc_pkg::REG_SETTLE_RELOAD;
    cfg_wdata_i <= reload_word;
    @(posedge clk_i);
    sb.write_reg(fmpsc_pkg::REG_SETTLE_RELOAD, reload_word);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    // Window edges, an upward jump with its settling run, band edges, then a downward jump.
    fmpsc_pkg::count_t opening_counts [25] = '{
      13'd0, 13'd8191, 13'd2109, 13'd3101, 13'd3100,
      13'd3055, 13'd3055, 13'd0, 13'd8191, 13'd3055, 13'd2500, 13'd3055,
      13'd3089, 13'd3090, 13'd3020, 13'd3021, 13'd2950,
      13'd2950, 13'd2950, 13'd0, 13'd8191, 13'd2950, 13'd2950, 13'd2950,
      13'd2955
    };
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= fmpsc_pkg::REG_VALID_MIN;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    period_count_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_counts[i]) send_count(opening_counts[i]);
    send_random(170);

    drain();
    set_config(13'd0, 13'd8191, 13'd8191, 13'h1FF0);
    send_random(40);

    drain();
    set_config(13'd0, 13'd8191, 13'd0, 13'd0);
    send_random(30);

    drain();
    set_config(13'd8191, 13'd0, 13'd0, 13'd15);
    send_random(20);

    drain();
    set_config(13'd2500, 13'd8191, 13'd30, 13'd15);
    send_random(40);

    drain();
    set_config(13'd2110, 13'd2600, 13'd8191, 13'd1);
    send_random(30);

    drain();
    set_config(fmpsc_pkg::VALID_MIN_RESET, fmpsc_pkg::VALID_MAX_RESET,
               fmpsc_pkg::JUMP_LIMIT_RESET,
               fmpsc_pkg::count_t'(fmpsc_pkg::SETTLE_RELOAD_RESET));
    idle_on = 1'b0;
    send_random(60);

    drain();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/fmpsc_pkg.sv
sv/fmpsc_cfg_regs.sv
sv/fmpsc_band_match.sv
sv/fm_period_symbol_classifier_core.sv
tb/tb_top.sv
